// ===== hw/rtl/sha1_message_digest_assert.svh =====
// Assertion macros shared by the SHA-1 digest checkers.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Clocked assertion, muted while reset is applied
`define SHA1MD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied
`define SHA1MD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sha1md_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 digest block.
// No dependencies; used by the queue, front, round core and top level.
package sha1md_pkg;

	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned DIG_WORDS = 5;
	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned SCHED_SEED = 16;

	// Block queue between front and round core
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	typedef logic [31:0] word_t;
	typedef word_t [BLK_WORDS-1:0] blk_t;
	typedef word_t [DIG_WORDS-1:0] chain_t;

	// Initial chaining value, word 0 in the low slot
	localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t K_CH   = 32'h5A827999;
	localparam word_t K_PAR1 = 32'h6ED9EBA1;
	localparam word_t K_MAJ  = 32'h8F1BBCDC;
	localparam word_t K_PAR2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Round phase codes
	localparam logic [1:0] PH_CH   = 2'd0;
	localparam logic [1:0] PH_PAR1 = 2'd1;
	localparam logic [1:0] PH_MAJ  = 2'd2;
	localparam logic [1:0] PH_PAR2 = 2'd3;

	typedef struct packed {
		blk_t words;
		logic last;
	} qent_t;

	typedef struct packed {
		logic  push;
		qent_t ent;
	} qpush_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic word_t round_f(logic [1:0] ph, word_t b, word_t c, word_t d);
		word_t f;
		case (ph)
			PH_CH:   f = (b & c) | (~b & d);
			PH_MAJ:  f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic word_t round_k(logic [1:0] ph);
		word_t k;
		case (ph)
			PH_CH:   k = K_CH;
			PH_PAR1: k = K_PAR1;
			PH_MAJ:  k = K_MAJ;
			default: k = K_PAR2;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/sha1_message_digest.sv =====
// SHA-1 digest top level: byte front, block queue and round core.
// Depends on sha1md_pkg, sha1md_front, sha1md_fifo and sha1md_core.
//
// Takes one message byte per word on the input channel and returns the
// 160-bit digest as five 32-bit words, most significant first, after the
// word marked end_of_message. The front accepts one byte per cycle while
// it has a free block slot; a full block waits in a two-entry queue. The
// round core loads each 64-byte block, runs 80 rounds through one
// five-input adder and adds the result into the chaining value. An end
// word adds one or two padding blocks (two when 56 or more bytes sit in
// the last block) and then the five digest words. The next message may
// start entering while this runs.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	sha1md_pkg::qpush_t wr;
	sha1md_pkg::qstat_t stat;
	sha1md_pkg::qent_t  rd_ent;
	logic               pop;

	sha1md_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.msg_byte      (msg_byte),
		.byte_present  (byte_present),
		.end_of_message(end_of_message),
		.wr            (wr),
		.stat          (stat)
	);

	sha1md_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.pop   (pop),
		.rd_ent(rd_ent),
		.stat  (stat)
	);

	sha1md_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_ent     (rd_ent),
		.stat       (stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digest_word(digest_word),
		.word_number(word_number),
		.final_word (final_word)
	);

endmodule

// ===== hw/rtl/sha1md_fifo.sv =====
// Two-entry block queue between the byte front and the round core.
// Depends on sha1md_pkg for the entry and control struct types.
module sha1md_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::qpush_t wr,
	input  logic               pop,
	output sha1md_pkg::qent_t  rd_ent,
	output sha1md_pkg::qstat_t stat
);

	sha1md_pkg::qent_t slot_q [sha1md_pkg::Q_DEPTH];
	logic [sha1md_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sha1md_pkg::Q_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign stat.full  = (cnt_q == sha1md_pkg::Q_CNT_W'(sha1md_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = wr.push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_ent     = slot_q[rd_ptr_q];

	// Store pushed block
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr.ent;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == sha1md_pkg::Q_PTR_W'(sha1md_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == sha1md_pkg::Q_PTR_W'(sha1md_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha1md_front.sv =====
// Byte intake: packs message bytes into blocks, pads the final block(s)
// and pushes finished blocks into the queue. Depends on sha1md_pkg.
module sha1md_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         msg_byte,
	input  logic               byte_present,
	input  logic               end_of_message,
	output sha1md_pkg::qpush_t wr,
	input  sha1md_pkg::qstat_t stat
);

	typedef enum logic [1:0] {
		F_ACCEPT,
		F_PUSH,
		F_PAD1,
		F_PAD2
	} fstate_t;

	fstate_t state_q;
	sha1md_pkg::blk_t blk_q;
	logic [5:0]  pos_q;
	logic [60:0] cnt_q;
	logic        pend_end_q;

	logic        take;
	logic        with_len;
	logic [3:0]  pos_w;
	logic [1:0]  pos_b;
	logic [63:0] bit_len;
	sha1md_pkg::word_t keep_mask, marker;
	sha1md_pkg::blk_t  pad_blk, len_blk;

	assign in_ready = (state_q == F_ACCEPT);
	assign take     = in_valid && in_ready;
	assign pos_w    = pos_q[5:2];
	assign pos_b    = pos_q[1:0];
	assign with_len = (pos_q[5:3] != 3'b111);
	assign bit_len  = {cnt_q, 3'b000};

	// Build the padded block and the length-only block
	always_comb begin
		keep_mask = ~(32'hFFFF_FFFF >> {pos_b, 3'b000});
		marker    = sha1md_pkg::word_t'(sha1md_pkg::PAD_BYTE) << {~pos_b, 3'b000};
		for (int i = 0; i < int'(sha1md_pkg::BLK_WORDS); i++) begin
			if (i < int'(pos_w)) begin
				pad_blk[i] = blk_q[i];
			end else if (i == int'(pos_w)) begin
				pad_blk[i] = (blk_q[i] & keep_mask) | marker;
			end else begin
				pad_blk[i] = '0;
			end
		end
		if (with_len) begin
			pad_blk[14] = bit_len[63:32];
			pad_blk[15] = bit_len[31:0];
		end
		len_blk     = '0;
		len_blk[14] = bit_len[63:32];
		len_blk[15] = bit_len[31:0];
	end

	// Select what goes to the queue
	always_comb begin
		wr.push = (state_q != F_ACCEPT);
		unique case (state_q)
			F_PAD1: begin
				wr.ent.words = pad_blk;
				wr.ent.last  = with_len;
			end
			F_PAD2: begin
				wr.ent.words = len_blk;
				wr.ent.last  = 1'b1;
			end
			default: begin
				wr.ent.words = blk_q;
				wr.ent.last  = 1'b0;
			end
		endcase
	end

	// Pack incoming byte into its word, big-endian
	always_ff @(posedge clk) begin
		if (take && byte_present) begin
			blk_q[pos_w] <= ((pos_b == 2'd0) ? '0 : blk_q[pos_w])
				| (sha1md_pkg::word_t'(msg_byte) << {~pos_b, 3'b000});
		end
	end

	// Intake and padding sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_ACCEPT;
			pos_q      <= '0;
			cnt_q      <= '0;
			pend_end_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_ACCEPT: begin
					if (take) begin
						pend_end_q <= end_of_message;
						if (byte_present) begin
							pos_q <= pos_q + 1'b1;
							cnt_q <= cnt_q + 1'b1;
							if (pos_q == 6'd63) begin
								state_q <= F_PUSH;
							end else if (end_of_message) begin
								state_q <= F_PAD1;
							end
						end else if (end_of_message) begin
							state_q <= F_PAD1;
						end
					end
				end
				F_PUSH: begin
					if (!stat.full) begin
						state_q <= pend_end_q ? F_PAD1 : F_ACCEPT;
					end
				end
				F_PAD1: begin
					if (!stat.full) begin
						if (with_len) begin
							pos_q   <= '0;
							cnt_q   <= '0;
							state_q <= F_ACCEPT;
						end else begin
							state_q <= F_PAD2;
						end
					end
				end
				F_PAD2: begin
					if (!stat.full) begin
						pos_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_ACCEPT;
					end
				end
				default: state_q <= F_ACCEPT;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha1md_core.sv =====
// Round core: pops blocks, runs 80 rounds with a rolling message schedule,
// folds into the chaining value and sends out the digest. Uses sha1md_pkg.
module sha1md_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::qent_t  rd_ent,
	input  sha1md_pkg::qstat_t stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_number,
	output logic               final_word
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_ADD,
		C_EMIT
	} cstate_t;

	cstate_t state_q;
	sha1md_pkg::chain_t chain_q;
	sha1md_pkg::blk_t   win_q;
	sha1md_pkg::word_t  a_q, b_q, c_q, d_q, e_q;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;
	logic       last_q;
	logic       out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_num_q;
	logic        out_final_q;

	logic [1:0]        ph;
	sha1md_pkg::word_t w_t, temp;
	logic              load_out;
	logic              emit_now;

	assign pop         = (state_q == C_IDLE) && !stat.empty;
	assign load_out    = !out_valid_q || out_ready;
	assign emit_now    = (state_q == C_EMIT) && load_out;
	assign out_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign word_number = out_num_q;
	assign final_word  = out_final_q;

	// Round function, schedule word and new A
	always_comb begin
		if (rnd_q < 7'd20) begin
			ph = sha1md_pkg::PH_CH;
		end else if (rnd_q < 7'd40) begin
			ph = sha1md_pkg::PH_PAR1;
		end else if (rnd_q < 7'd60) begin
			ph = sha1md_pkg::PH_MAJ;
		end else begin
			ph = sha1md_pkg::PH_PAR2;
		end
		if (rnd_q < 7'(sha1md_pkg::SCHED_SEED)) begin
			w_t = win_q[0];
		end else begin
			w_t = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
			w_t = {w_t[30:0], w_t[31]};
		end
		temp = {a_q[26:0], a_q[31:27]} + sha1md_pkg::round_f(ph, b_q, c_q, d_q)
			+ e_q + sha1md_pkg::round_k(ph) + w_t;
	end

	// Schedule window and working variables
	always_ff @(posedge clk) begin
		if (pop) begin
			win_q <= rd_ent.words;
			a_q   <= chain_q[0];
			b_q   <= chain_q[1];
			c_q   <= chain_q[2];
			d_q   <= chain_q[3];
			e_q   <= chain_q[4];
		end else if (state_q == C_ROUND) begin
			win_q <= {w_t, win_q[15:1]};
			e_q   <= d_q;
			d_q   <= c_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			b_q   <= a_q;
			a_q   <= temp;
		end
	end

	// Compression sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			chain_q     <= sha1md_pkg::IV;
			rnd_q       <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_num_q   <= '0;
			out_final_q <= 1'b0;
		end else begin
			// Load the next digest word, or drop the one just taken
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				C_IDLE: begin
					if (pop) begin
						last_q  <= rd_ent.last;
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'(sha1md_pkg::ROUNDS - 1)) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					rnd_q      <= '0;
					idx_q      <= '0;
					state_q    <= last_q ? C_EMIT : C_IDLE;
				end
				C_EMIT: begin
					if (load_out) begin
						out_word_q  <= chain_q[idx_q];
						out_num_q   <= idx_q;
						out_final_q <= (idx_q == 3'(sha1md_pkg::DIG_WORDS - 1));
						if (idx_q == 3'(sha1md_pkg::DIG_WORDS - 1)) begin
							chain_q <= sha1md_pkg::IV;
							state_q <= C_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha1md_checker.sv =====
// Port-level checker for the SHA-1 digest block, bound to the top level.
// Depends on sha1_message_digest_assert.svh for the assertion macros.
`include "sha1_message_digest_assert.svh"

module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_number,
	input logic        final_word
);

	// Hold a stalled digest word
	`SHA1MD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_number) && $stable(final_word), "stalled digest word changed")

	// Flag the last word exactly on word four
	`SHA1MD_ASSERT(a_final_pos, out_valid |-> (final_word == (word_number == 3'd4)), "final flag off position")

	// Advance the digest words back to back
	`SHA1MD_ASSERT(a_word_seq, out_valid && out_ready && !final_word |=> out_valid && (word_number == $past(word_number) + 3'd1), "digest word sequence broken")

	// Drop intake while an end word is padded
	`SHA1MD_ASSERT(a_end_stall, in_valid && in_ready && end_of_message |=> !in_ready, "intake open during padding")

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);
